// ===== rtl/core/fpa_pkg.sv =====
package fpa_pkg;

  localparam int ValueWidth = 16;
  localparam int DenWidth = ValueWidth - 1;
  localparam int FractionBits = 16;
  localparam int QWidth = 32;
  localparam int ProdWidth = 2 * ValueWidth;
  localparam int NumWideWidth = ProdWidth + 2;
  localparam int DivWidth = NumWideWidth + FractionBits + 2;
  localparam int DivCountWidth = $clog2(DivWidth + 1);

  localparam logic [1:0] OrderLess = 2'd0;
  localparam logic [1:0] OrderEqual = 2'd1;
  localparam logic [1:0] OrderGreater = 2'd2;

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusBadDen = 2'd1;
  localparam logic [1:0] StatusNoQuot = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_GCD_LOAD,
    ST_GCD_TWOS,
    ST_GCD_ODD_A,
    ST_GCD_ODD_B,
    ST_GCD_SUB,
    ST_GCD_DONE,
    ST_RED_DIV_N,
    ST_RED_DIV_D,
    ST_MUL_X1,
    ST_MUL_X2,
    ST_MUL_DEN,
    ST_MUL_AC,
    ST_MUL_BC,
    ST_FIX_START,
    ST_FIX_DIV,
    ST_FIX_DONE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic signed [ValueWidth-1:0] red_num_first;
    logic [DenWidth-1:0] red_den_first;
    logic signed [ValueWidth-1:0] red_num_second;
    logic [DenWidth-1:0] red_den_second;
    logic signed [QWidth-1:0] sum_value;
    logic signed [QWidth-1:0] difference_value;
    logic signed [QWidth-1:0] product_value;
    logic signed [QWidth-1:0] quotient_value;
    logic [1:0] order;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    logic signed [ValueWidth-1:0] num_first;
    logic signed [ValueWidth-1:0] den_first;
    logic signed [ValueWidth-1:0] num_second;
    logic signed [ValueWidth-1:0] den_second;
  } request_t;

endpackage

// ===== rtl/core/fpa_if.sv =====
interface fpa_in_if;
  logic valid;
  logic ready;
  fpa_pkg::request_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface fpa_out_if;
  logic valid;
  logic ready;
  fpa_pkg::result_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/core/fraction_pair_arithmetic.sv =====
// Channel   Direction  Payload
// req       sink       num_first, den_first, num_second, den_second
// rsp       source     reduced fractions, four Q16.16 values, order, status
// A request runs two binary GCD loops, one subtract or shift per step. Four
// 16-step restoring divisions reduce the fractions, five multiply states form
// the cross products, and four 52-step restoring divisions give the fixed-point
// values; all divisions share one subtractor. A request with a non-positive
// denominator skips from the GCD load state straight to the output state.
// Reset is synchronous and returns the sequencer to idle; req is ready only
// in idle. The result register holds until rsp is taken, and a finished
// request waits in the output state while the previous result is held.
module fraction_pair_arithmetic (
  input logic clk,
  input logic rst,
  fpa_in_if.sink req,
  fpa_out_if.source rsp
);

  localparam int VW = fpa_pkg::ValueWidth;
  localparam int PW = fpa_pkg::ProdWidth;
  localparam int NW = fpa_pkg::NumWideWidth;
  localparam int DW = fpa_pkg::DivWidth;
  localparam int CW = fpa_pkg::DivCountWidth;
  localparam int FB = fpa_pkg::FractionBits;
  localparam int QW = fpa_pkg::QWidth;

  function automatic logic signed [QW-1:0] sat_q(input logic [DW-1:0] q, input logic neg);
    logic [DW-1:0] lim;
    lim = DW'(64'h8000_0000);
    if (neg) begin
      if (q > lim) sat_q = {1'b1, {(QW-1){1'b0}}};
      else sat_q = QW'(-q);
    end else begin
      if (q >= lim) sat_q = {1'b0, {(QW-1){1'b1}}};
      else sat_q = QW'(q);
    end
  endfunction

  fpa_pkg::state_t state, state_next;

  fpa_pkg::request_t in_reg;
  fpa_pkg::result_t res;
  fpa_pkg::result_t res_fill;
  logic out_valid;

  logic pass;
  logic [VW-1:0] ga, gb;
  logic [4:0] gk;
  logic [VW-1:0] gcd_val;
  logic signed [VW:0] a_num, b_num;
  logic [VW-1:0] a_den, b_den;

  logic [DW-1:0] div_rem, div_quo, div_dvsr;
  logic [DW-1:0] div_dvd;
  logic [CW-1:0] div_cnt;
  logic [DW:0] div_trial;

  logic signed [NW-1:0] x1, x2, den_p, ac_p, bc_p;
  logic signed [NW-1:0] mul_a, mul_b;
  logic signed [NW-1:0] mul_p;
  logic [1:0] fix_sel;
  logic fix_neg;
  logic signed [NW-1:0] fix_n, fix_d;
  logic signed [QW-1:0] sum_w, diff_w, prod_w, quot_w;
  logic [VW-1:0] abs_num;
  logic bad_den;

  assign req.ready = (state == fpa_pkg::ST_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data = res;

  assign bad_den = (in_reg.den_first <= 0) || (in_reg.den_second <= 0);
  assign abs_num = pass ? (in_reg.num_second[VW-1] ? VW'(-in_reg.num_second)
                                                    : in_reg.num_second)
                        : (in_reg.num_first[VW-1] ? VW'(-in_reg.num_first)
                                                  : in_reg.num_first);
  assign div_trial = {div_rem, div_dvd[DW-1]} - {1'b0, div_dvsr};
  assign mul_p = NW'(mul_a * mul_b);

  always_comb begin
    case (fix_sel)
      2'd0: begin
        fix_n = x1 + x2;
        fix_d = den_p;
      end
      2'd1: begin
        fix_n = x1 - x2;
        fix_d = den_p;
      end
      2'd2: begin
        fix_n = ac_p;
        fix_d = den_p;
      end
      default: begin
        fix_n = x1;
        fix_d = bc_p;
      end
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      fpa_pkg::ST_MUL_X1: begin
        mul_a = NW'(a_num);
        mul_b = NW'($signed({1'b0, b_den}));
      end
      fpa_pkg::ST_MUL_X2: begin
        mul_a = NW'(b_num);
        mul_b = NW'($signed({1'b0, a_den}));
      end
      fpa_pkg::ST_MUL_DEN: begin
        mul_a = NW'($signed({1'b0, a_den}));
        mul_b = NW'($signed({1'b0, b_den}));
      end
      fpa_pkg::ST_MUL_AC: begin
        mul_a = NW'(a_num);
        mul_b = NW'(b_num);
      end
      fpa_pkg::ST_MUL_BC: begin
        mul_a = NW'($signed({1'b0, a_den}));
        mul_b = NW'(b_num);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    res_fill = '0;
    if (bad_den) begin
      res_fill.status = fpa_pkg::StatusBadDen;
    end else begin
      res_fill.red_num_first = VW'(a_num);
      res_fill.red_den_first = a_den[VW-2:0];
      res_fill.red_num_second = VW'(b_num);
      res_fill.red_den_second = b_den[VW-2:0];
      res_fill.sum_value = sum_w;
      res_fill.difference_value = diff_w;
      res_fill.product_value = prod_w;
      res_fill.quotient_value = quot_w;
      res_fill.order = (x1 < x2) ? fpa_pkg::OrderLess
                     : (x1 == x2) ? fpa_pkg::OrderEqual : fpa_pkg::OrderGreater;
      res_fill.status = (b_num == 0) ? fpa_pkg::StatusNoQuot : fpa_pkg::StatusOk;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      fpa_pkg::ST_IDLE: if (req.valid) state_next = fpa_pkg::ST_GCD_LOAD;
      fpa_pkg::ST_GCD_LOAD: begin
        if (bad_den) state_next = fpa_pkg::ST_OUT;
        else if (abs_num == '0) state_next = fpa_pkg::ST_GCD_DONE;
        else state_next = fpa_pkg::ST_GCD_TWOS;
      end
      fpa_pkg::ST_GCD_TWOS: if ((ga[0] | gb[0]) == 1'b1) state_next = fpa_pkg::ST_GCD_ODD_A;
      fpa_pkg::ST_GCD_ODD_A: if (ga[0]) state_next = fpa_pkg::ST_GCD_ODD_B;
      fpa_pkg::ST_GCD_ODD_B: begin
        if (gb == '0) state_next = fpa_pkg::ST_GCD_DONE;
        else if (gb[0]) state_next = fpa_pkg::ST_GCD_SUB;
      end
      fpa_pkg::ST_GCD_SUB: state_next = fpa_pkg::ST_GCD_ODD_B;
      fpa_pkg::ST_GCD_DONE: state_next = fpa_pkg::ST_RED_DIV_N;
      fpa_pkg::ST_RED_DIV_N: if (div_cnt == '0) state_next = fpa_pkg::ST_RED_DIV_D;
      fpa_pkg::ST_RED_DIV_D: begin
        if (div_cnt == '0) state_next = pass ? fpa_pkg::ST_MUL_X1 : fpa_pkg::ST_GCD_LOAD;
      end
      fpa_pkg::ST_MUL_X1: state_next = fpa_pkg::ST_MUL_X2;
      fpa_pkg::ST_MUL_X2: state_next = fpa_pkg::ST_MUL_DEN;
      fpa_pkg::ST_MUL_DEN: state_next = fpa_pkg::ST_MUL_AC;
      fpa_pkg::ST_MUL_AC: state_next = fpa_pkg::ST_MUL_BC;
      fpa_pkg::ST_MUL_BC: state_next = fpa_pkg::ST_FIX_START;
      fpa_pkg::ST_FIX_START: state_next = fpa_pkg::ST_FIX_DIV;
      fpa_pkg::ST_FIX_DIV: if (div_cnt == '0) state_next = fpa_pkg::ST_FIX_DONE;
      fpa_pkg::ST_FIX_DONE: begin
        if (fix_sel == 2'd3) state_next = fpa_pkg::ST_OUT;
        else state_next = fpa_pkg::ST_FIX_START;
      end
      fpa_pkg::ST_OUT: if (!out_valid || rsp.ready) state_next = fpa_pkg::ST_IDLE;
      default: state_next = fpa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpa_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp.ready) out_valid <= 1'b0;
      if (state == fpa_pkg::ST_OUT && (!out_valid || rsp.ready)) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      fpa_pkg::ST_IDLE: begin
        in_reg <= req.data;
        pass <= 1'b0;
        fix_sel <= 2'd0;
      end
      fpa_pkg::ST_GCD_LOAD: begin
        ga <= abs_num;
        gb <= pass ? in_reg.den_second : in_reg.den_first;
        gk <= '0;
      end
      fpa_pkg::ST_GCD_TWOS: begin
        if ((ga[0] | gb[0]) == 1'b0) begin
          ga <= ga >> 1;
          gb <= gb >> 1;
          gk <= gk + 5'd1;
        end
      end
      fpa_pkg::ST_GCD_ODD_A: if (!ga[0]) ga <= ga >> 1;
      fpa_pkg::ST_GCD_ODD_B: if (gb != '0 && !gb[0]) gb <= gb >> 1;
      fpa_pkg::ST_GCD_SUB: begin
        if (ga > gb) begin
          ga <= gb;
          gb <= ga - gb;
        end else begin
          gb <= gb - ga;
        end
      end
      fpa_pkg::ST_GCD_DONE: begin
        gcd_val <= (abs_num == '0) ? abs_num : VW'(ga << gk);
        div_rem <= '0;
        div_dvd <= {abs_num, {(DW-VW){1'b0}}};
        div_dvsr <= DW'(VW'((abs_num == '0) ? 1 : ga << gk));
        div_cnt <= CW'(VW);
      end
      fpa_pkg::ST_RED_DIV_N, fpa_pkg::ST_RED_DIV_D: begin
        if (div_cnt != '0) begin
          div_dvd <= div_dvd << 1;
          if (!div_trial[DW]) begin
            div_rem <= div_trial[DW-1:0];
            div_quo <= {div_quo[DW-2:0], 1'b1};
          end else begin
            div_rem <= {div_rem[DW-2:0], div_dvd[DW-1]};
            div_quo <= {div_quo[DW-2:0], 1'b0};
          end
          div_cnt <= div_cnt - 1'b1;
        end else if (state == fpa_pkg::ST_RED_DIV_N) begin
          if (pass) b_num <= (in_reg.num_second[VW-1] ? -$signed({1'b0, div_quo[VW-1:0]})
                                                      : $signed({1'b0, div_quo[VW-1:0]}));
          else a_num <= (in_reg.num_first[VW-1] ? -$signed({1'b0, div_quo[VW-1:0]})
                                               : $signed({1'b0, div_quo[VW-1:0]}));
          div_rem <= '0;
          div_quo <= '0;
          div_dvd <= {(pass ? in_reg.den_second : in_reg.den_first), {(DW-VW){1'b0}}};
          div_dvsr <= DW'(gcd_val == '0 ? VW'(pass ? in_reg.den_second : in_reg.den_first)
                                        : gcd_val);
          div_cnt <= CW'(VW);
        end else begin
          if (pass) b_den <= div_quo[VW-1:0];
          else a_den <= div_quo[VW-1:0];
          pass <= 1'b1;
        end
      end
      fpa_pkg::ST_MUL_X1: x1 <= mul_p;
      fpa_pkg::ST_MUL_X2: x2 <= mul_p;
      fpa_pkg::ST_MUL_DEN: den_p <= mul_p;
      fpa_pkg::ST_MUL_AC: ac_p <= mul_p;
      fpa_pkg::ST_MUL_BC: bc_p <= mul_p;
      fpa_pkg::ST_FIX_START: begin
        fix_neg <= fix_n[NW-1] ^ fix_d[NW-1];
        div_rem <= '0;
        div_quo <= '0;
        div_dvd <= DW'({(fix_n[NW-1] ? -fix_n : fix_n), {(FB+1){1'b0}}})
                 + DW'(fix_d[NW-1] ? -fix_d : fix_d);
        div_dvsr <= DW'({(fix_d[NW-1] ? -fix_d : fix_d), 1'b0});
        div_cnt <= CW'(DW);
      end
      fpa_pkg::ST_FIX_DIV: begin
        if (div_cnt != '0) begin
          div_dvd <= div_dvd << 1;
          if (!div_trial[DW]) begin
            div_rem <= div_trial[DW-1:0];
            div_quo <= {div_quo[DW-2:0], 1'b1};
          end else begin
            div_rem <= {div_rem[DW-2:0], div_dvd[DW-1]};
            div_quo <= {div_quo[DW-2:0], 1'b0};
          end
          div_cnt <= div_cnt - 1'b1;
        end
      end
      fpa_pkg::ST_FIX_DONE: begin
        fix_sel <= fix_sel + 2'd1;
        case (fix_sel)
          2'd0: sum_w <= sat_q(div_quo, fix_neg);
          2'd1: diff_w <= sat_q(div_quo, fix_neg);
          2'd2: prod_w <= sat_q(div_quo, fix_neg);
          default: quot_w <= (b_num == 0) ? '0 : sat_q(div_quo, fix_neg);
        endcase
      end
      fpa_pkg::ST_OUT: begin
        if (!out_valid || rsp.ready) res <= res_fill;
      end
      default: ;
    endcase
  end

endmodule

// ===== sim/tb_fraction_pair_arithmetic.sv =====
module tb_fraction_pair_arithmetic;

  localparam int IdleLimit = 20000;

  logic clk;
  logic rst;

  fpa_in_if req ();
  fpa_out_if rsp ();

  fraction_pair_arithmetic u_dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  fpa_pkg::result_t pending_results[$];
  int error_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int bad_den_count = 0;
  int no_quot_count = 0;
  int idle_cycles = 0;
  bit allow_gaps = 1;
  bit hold_off = 0;
  int hold_cycles = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] stein_gcd(logic [63:0] a, logic [63:0] b);
    int k;
    logic [63:0] t;
    k = 0;
    while (((a | b) & 1) == 0) begin
      a = a >> 1;
      b = b >> 1;
      k++;
    end
    while ((a & 1) == 0) a = a >> 1;
    while (b != 0) begin
      while ((b & 1) == 0) b = b >> 1;
      if (a > b) begin
        t = a;
        a = b;
        b = t;
      end
      b = b - a;
    end
    return a << k;
  endfunction

  function automatic logic signed [31:0] fixed_ratio(longint n, longint d);
    bit neg;
    logic [63:0] mn;
    logic [63:0] md;
    logic [63:0] q;
    neg = (n < 0) != (d < 0);
    mn = (n < 0) ? -n : n;
    md = (d < 0) ? -d : d;
    if (n == 0) return '0;
    q = ((mn << (fpa_pkg::FractionBits + 1)) + md) / (md * 2);
    if (neg) begin
      if (q > 64'd2147483648) return 32'sh8000_0000;
      return 32'(-q);
    end
    if (q > 64'd2147483647) return 32'sh7fff_ffff;
    return 32'(q);
  endfunction

  function automatic void reduce_fraction(input longint n, input longint d,
                                          output longint rn, output longint rd);
    logic [63:0] an;
    logic [63:0] g;
    if (n == 0) begin
      rn = 0;
      rd = 1;
    end else begin
      an = (n < 0) ? -n : n;
      g = stein_gcd(an, d);
      an = an / g;
      rn = (n < 0) ? -longint'(an) : longint'(an);
      rd = d / longint'(g);
    end
  endfunction

  function automatic fpa_pkg::result_t fraction_results(fpa_pkg::request_t r);
    fpa_pkg::result_t res;
    longint a, b, c, e, x1, x2, den;
    res = '0;
    if (r.den_first <= 0 || r.den_second <= 0) begin
      res.status = fpa_pkg::StatusBadDen;
      return res;
    end
    reduce_fraction(r.num_first, r.den_first, a, b);
    reduce_fraction(r.num_second, r.den_second, c, e);
    res.red_num_first = 16'(a);
    res.red_den_first = 15'(b);
    res.red_num_second = 16'(c);
    res.red_den_second = 15'(e);
    x1 = a * e;
    x2 = c * b;
    den = b * e;
    res.sum_value = fixed_ratio(x1 + x2, den);
    res.difference_value = fixed_ratio(x1 - x2, den);
    res.product_value = fixed_ratio(a * c, den);
    if (c == 0) begin
      res.quotient_value = '0;
      res.status = fpa_pkg::StatusNoQuot;
    end else begin
      res.quotient_value = fixed_ratio(x1, b * c);
      res.status = fpa_pkg::StatusOk;
    end
    res.order = (x1 < x2) ? fpa_pkg::OrderLess
              : ((x1 == x2) ? fpa_pkg::OrderEqual : fpa_pkg::OrderGreater);
    return res;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("MISMATCH result %0d field %s: got %0d expected %0d",
             checked_count, field, got, want);
    error_count++;
  endtask

  task automatic send_request(input logic signed [15:0] n1, input logic signed [15:0] d1,
                              input logic signed [15:0] n2, input logic signed [15:0] d2);
    fpa_pkg::request_t r;
    int gap;
    r.num_first = n1;
    r.den_first = d1;
    r.num_second = n2;
    r.den_second = d2;
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.data <= r;
    do @(posedge clk); while (!req.ready);
    pending_results.push_back(fraction_results(r));
    sent_count++;
    if (r.den_first <= 0 || r.den_second <= 0) bad_den_count++;
    else if (r.num_second == 0) no_quot_count++;
  endtask

  task automatic release_request();
    req.valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] any_value();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($urandom_range(0, 16) - 8);
      3: return 16'($urandom_range(0, 512) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [15:0] good_den();
    case ($urandom_range(0, 4))
      0: return 16'sh7fff;
      1: return 16'($urandom_range(1, 16));
      2: return 16'($urandom_range(1, 4) << $urandom_range(0, 12));
      default: return 16'($urandom_range(1, 32767));
    endcase
  endfunction

  task automatic test_directed();
    send_request(1, 2, 1, 3);
    send_request(0, 5, 3, 9);
    send_request(4, 8, 0, 7);
    send_request(-32768, 1, 1, 32767);
    send_request(32767, 1, -32768, 1);
    send_request(-32768, 32767, -32768, 32767);
    send_request(32767, 32767, 32767, 1);
    send_request(-6, 4, 6, 4);
    send_request(-32768, 16384, 12, 8);
    send_request(1, 0, 1, 1);
    send_request(1, 1, 1, 0);
    send_request(5, -3, 2, 7);
    send_request(5, 3, 2, -32768);
    send_request(0, 0, 0, -1);
    send_request(1, 32767, -1, 32767);
    send_request(-1, 32767, 1, 2);
    send_request(32767, 1, 1, 32767);
    send_request(-16384, 16384, -4096, 8192);
  endtask

  task automatic test_random(input int count);
    logic signed [15:0] d1, d2;
    repeat (count) begin
      d1 = good_den();
      d2 = good_den();
      if ($urandom_range(0, 19) == 0)
        d1 = 16'($urandom_range(0, 1) ? 0 : -$urandom_range(1, 32768));
      if ($urandom_range(0, 19) == 0) d2 = 16'($urandom_range(0, 1) ? $urandom : 0);
      send_request(any_value(), d1, $urandom_range(0, 15) == 0 ? 16'sd0 : any_value(), d2);
    end
  endtask

  task automatic test_backpressure();
    hold_cycles = 2000;
    hold_off = 1;
    test_random(4);
    release_request();
    wait (hold_off == 0);
    @(posedge clk);
  endtask

  task automatic test_full_rate();
    allow_gaps = 0;
    test_random(100);
  endtask

  initial begin
    rst = 1'b1;
    req.valid = 1'b0;
    req.data = '0;
    rsp.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(820);
    test_backpressure();
    test_random(100);
    test_full_rate();
    release_request();
    wait (pending_results.size() == 0);
    repeat (500) @(posedge clk);
    $display("Sent %0d requests (%0d bad denominators, %0d zero divisors), checked %0d results.",
             sent_count, bad_den_count, no_quot_count, checked_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        rsp.ready <= 1'b0;
        hold_cycles--;
        if (hold_cycles <= 0) hold_off = 0;
      end else if (allow_gaps && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 15);
        rsp.ready <= 1'b0;
        repeat (gap - 1) @(posedge clk);
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    fpa_pkg::result_t want;
    fpa_pkg::result_t got;
    if (!rst && rsp.valid && rsp.ready) begin
      got = rsp.data;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        want = pending_results.pop_front();
        if (got.red_num_first !== want.red_num_first)
          report_mismatch("red_num_first", got.red_num_first, want.red_num_first);
        if (got.red_den_first !== want.red_den_first)
          report_mismatch("red_den_first", got.red_den_first, want.red_den_first);
        if (got.red_num_second !== want.red_num_second)
          report_mismatch("red_num_second", got.red_num_second, want.red_num_second);
        if (got.red_den_second !== want.red_den_second)
          report_mismatch("red_den_second", got.red_den_second, want.red_den_second);
        if (got.sum_value !== want.sum_value)
          report_mismatch("sum_value", got.sum_value, want.sum_value);
        if (got.difference_value !== want.difference_value)
          report_mismatch("difference_value", got.difference_value, want.difference_value);
        if (got.product_value !== want.product_value)
          report_mismatch("product_value", got.product_value, want.product_value);
        if (got.quotient_value !== want.quotient_value)
          report_mismatch("quotient_value", got.quotient_value, want.quotient_value);
        if (got.order !== want.order) report_mismatch("order", got.order, want.order);
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
      end
      checked_count++;
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Watchdog expired with %0d results outstanding.", pending_results.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule
